### design/ps2med_pkg.sv
package ps2med_pkg;

    // Bit in the first byte of a packet that is always set by the mouse.
    localparam logic [7:0] FLAG_SYNC_MASK     = 8'h08;
    // X and Y overflow bits of the first byte.
    localparam logic [7:0] FLAG_OVERFLOW_MASK = 8'hC0;
    // Left, right and middle button bits of the first byte.
    localparam logic [7:0] FLAG_BUTTON_MASK   = 8'h07;

    localparam int unsigned NUM_BUTTONS = 3;
    // One slot per button plus one for the move event.
    localparam int unsigned NUM_SLOTS   = NUM_BUTTONS + 1;

    // Event kinds on the result channel.
    localparam logic EVENT_BUTTON = 1'b0;
    localparam logic EVENT_MOVE   = 1'b1;

    // Button levels.
    localparam logic [7:0] LEVEL_RELEASED = 8'd0;
    localparam logic [7:0] LEVEL_PRESSED  = 8'd1;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

endpackage

### design/ps2_mouse_packet_event_decoder.sv
// PS/2 mouse packet event decoder.
// The s_ channel takes one byte per transfer from a PS/2 controller together
// with a flag that marks it as auxiliary (mouse) data; keyboard bytes are
// dropped. Mouse bytes are assembled into three-byte packets. When a packet
// completes without overflow, the block produces one button event for each
// of left, right and middle that changed since the last packet, in that
// order, followed by one move event if either delta is nonzero. m_last marks
// the final event of a packet.
// The events of a packet are offered on the m_ channel in the cycle after
// its third byte is taken. A byte that produces no event does not hold up
// the next byte; a completing packet occupies the result register until
// all its events (up to four) are transferred, since the result channel
// carries one event per transfer. The next byte is taken in the same cycle
// the final event of the previous packet is transferred.
// Reset (synchronous, active low) clears the packet phase, the stored packet
// bytes, the held buttons and any pending events.
// While the receiver holds m_ready low, the current event stays on m_ and
// s_ready stays low once the pending events cannot be cleared this cycle.
module ps2_mouse_packet_event_decoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_from_aux,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_event_kind,
    output logic signed [7:0]                 m_code_or_dx,
    output logic signed [7:0]                 m_level_or_dy,
    output logic                              m_last
);
    import ps2med_pkg::*;

    localparam logic [1:0] PHASE_FLAG = 2'd0;
    localparam logic [1:0] PHASE_X    = 2'd1;
    localparam logic [1:0] PHASE_Y    = 2'd2;

    logic [1:0]             phase_reg, phase_next;
    logic [7:0]             flag_reg, flag_next;
    logic [7:0]             x_reg, x_next;
    logic [NUM_BUTTONS-1:0] held_reg, held_next;

    // Pending events of the last completed packet.
    slot_mask_t             pend_reg, pend_next;
    logic [NUM_BUTTONS-1:0] pend_level_reg, pend_level_next;
    logic [7:0]             pend_dx_reg, pend_dx_next;
    logic [7:0]             pend_dy_reg, pend_dy_next;

    logic                   s_fire;
    logic                   m_fire;
    slot_mask_t             pend_rest;
    logic [1:0]             sel_idx;
    logic [NUM_BUTTONS-1:0] now_buttons;
    logic [NUM_BUTTONS-1:0] changed;
    logic [7:0]             dy_neg;

    // Clearing the lowest set bit leaves the events still to go.
    assign pend_rest = pend_reg & (pend_reg - slot_mask_t'(1));

    assign m_valid = (pend_reg != '0);
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (pend_reg == '0) || (m_ready && (pend_rest == '0));
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (pend_reg[0]) begin
            sel_idx = 2'd0;
        end else if (pend_reg[1]) begin
            sel_idx = 2'd1;
        end else if (pend_reg[2]) begin
            sel_idx = 2'd2;
        end else begin
            sel_idx = 2'd3;
        end
    end

    always_comb begin
        if (sel_idx == 2'd3) begin
            m_event_kind  = EVENT_MOVE;
            m_code_or_dx  = pend_dx_reg;
            m_level_or_dy = pend_dy_reg;
        end else begin
            m_event_kind  = EVENT_BUTTON;
            m_code_or_dx  = {6'd0, sel_idx} + 8'd1;
            m_level_or_dy = pend_level_reg[sel_idx] ? LEVEL_PRESSED : LEVEL_RELEASED;
        end
        m_last = (pend_rest == '0);
    end

    assign now_buttons = flag_reg[NUM_BUTTONS-1:0] & FLAG_BUTTON_MASK[NUM_BUTTONS-1:0];
    assign changed     = held_reg ^ now_buttons;
    assign dy_neg      = 8'd0 - s_data_byte;

    always_comb begin
        phase_next      = phase_reg;
        flag_next       = flag_reg;
        x_next          = x_reg;
        held_next       = held_reg;
        pend_next       = pend_reg;
        pend_level_next = pend_level_reg;
        pend_dx_next    = pend_dx_reg;
        pend_dy_next    = pend_dy_reg;

        if (m_fire) begin
            pend_next = pend_rest;
        end

        if (s_fire && s_from_aux) begin
            case (phase_reg)
                PHASE_X: begin
                    x_next     = s_data_byte;
                    phase_next = PHASE_Y;
                end
                PHASE_Y: begin
                    phase_next = PHASE_FLAG;
                    if ((flag_reg & FLAG_OVERFLOW_MASK) == 8'd0) begin
                        held_next       = now_buttons;
                        pend_level_next = now_buttons;
                        pend_dx_next    = x_reg;
                        pend_dy_next    = dy_neg;
                        pend_next       = {(x_reg != 8'd0) || (dy_neg != 8'd0), changed};
                    end
                end
                default: begin
                    // The flag byte always has its sync bit set; anything
                    // else is dropped so that the packet boundary is found.
                    if ((s_data_byte & FLAG_SYNC_MASK) != 8'd0) begin
                        flag_next  = s_data_byte;
                        phase_next = PHASE_X;
                    end else begin
                        phase_next = PHASE_FLAG;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_FLAG;
            flag_reg  <= 8'd0;
            x_reg     <= 8'd0;
            held_reg  <= '0;
            pend_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            x_reg     <= x_next;
            held_reg  <= held_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_level_reg <= pend_level_next;
        pend_dx_reg    <= pend_dx_next;
        pend_dy_reg    <= pend_dy_next;
    end

`ifndef SYNTHESIS
    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("packet phase reached an unused code");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("event offered right after reset");

    a_move_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EVENT_MOVE)) |-> m_last)
        else $error("move event not marked as the final event");

    a_button_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_kind == EVENT_BUTTON)) |->
            ((m_code_or_dx == 8'sd1) || (m_code_or_dx == 8'sd2) ||
             (m_code_or_dx == 8'sd3)))
        else $error("button event with an invalid button number");

    a_overflow_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_from_aux && (phase_reg == PHASE_Y) &&
         ((flag_reg & FLAG_OVERFLOW_MASK) != 8'd0)) |=> !m_valid)
        else $error("overflowed packet produced events");
`endif

endmodule
